// ===== rtl/cpeq_pkg.sv =====
// shared types and constants for the card presence event qualifier
package cpeq_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned UID_LO_BITS = 64;
  localparam int unsigned UID_HI_BITS = 16;
  localparam int unsigned ADDR_BITS = 5;

  localparam logic [TIME_BITS-1:0] SETTLE_MS = TIME_BITS'(40);
  localparam logic [TIME_BITS-1:0] ENABLE_READ_RESET_MS = TIME_BITS'(60);
  localparam logic [TIME_BITS-1:0] ENABLE_SUPPRESS_DEFAULT = TIME_BITS'(2500);
  localparam logic [3:0] UID_MAX_LEN = 4'd10;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [15:0] RST_REMOVE_TIME = 16'd500;
  localparam logic [7:0] RST_REINIT_MISSES = 8'd8;
  localparam logic [15:0] RST_READ_CONFIRM_MS = 16'd90;
  localparam logic [7:0] RST_READ_CONFIRM_CNT = 8'd2;
  localparam logic [15:0] RST_REMOVE_GRACE = 16'd180;
  localparam logic [15:0] RST_REFRACTORY = 16'd250;
  localparam logic [15:0] RST_ENABLE_SUPPRESS = 16'd180;
  localparam logic [15:0] RST_BOOT_WARMUP = 16'd2500;

  typedef enum logic [1:0] {
    CMD_POLL    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_READ   = 2'd1,
    EV_REMOVE = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    REG_REMOVE_TIME     = 3'd0,
    REG_REINIT_MISSES   = 3'd1,
    REG_READ_CONFIRM_MS = 3'd2,
    REG_READ_CONFIRM_CNT = 3'd3,
    REG_REMOVE_GRACE    = 3'd4,
    REG_REFRACTORY      = 3'd5,
    REG_ENABLE_SUPPRESS = 3'd6,
    REG_BOOT_WARMUP     = 3'd7
  } reg_idx_e;

endpackage

// ===== rtl/card_presence_event_qualifier_core.sv =====
// card presence event qualifier: poll/command input, event result, apb config
//
// input channel (in_valid_i/in_ready_o): one transaction per poll result or
//   enable/disable command; cmd_i selects which, the other fields carry time
//   and the card answer with its uid
// output channel (out_valid_o/out_ready_i): exactly one result transaction
//   per input transaction, in order: event kind, uid of a read event,
//   reinit request and the published card flag after the item
// datapath: input register, then one pass of compare/add logic that updates
//   the qualifier state and loads the result register
// result path: the item is caught in the input register when accepted and its result
//   is loaded into the result register when the item advances
// throughput: one transaction per cycle; the input register and the result
//   register form a two-entry pipe, so a new item is taken while a result
//   waits, and only a full pipe with a stalled receiver drops in_ready_o
// stall: when out_ready_i is low the result holds, the input register holds
//   its item and in_ready_o falls in the same cycle once both registers are full
// reset: rst_ni low clears the pipe, restores the register defaults and the
//   qualifier state (reader enabled, no card, removal suppressed until 2500)
// config: apb registers at 4*i; the user must write them only while the block is
//   idle, the block itself does not enforce this; pready is always high
module card_presence_event_qualifier_core
  import cpeq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [TIME_BITS-1:0]   now_ms_i,
  input  logic                   card_answered_i,
  input  logic                   uid_read_ok_i,
  input  logic [UID_LO_BITS-1:0] uid_low_i,
  input  logic [UID_HI_BITS-1:0] uid_high_i,
  input  logic [3:0]             uid_length_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             event_res_o,
  output logic [UID_LO_BITS-1:0] event_uid_low_o,
  output logic [UID_HI_BITS-1:0] event_uid_high_o,
  output logic                   reinit_request_o,
  output logic                   card_published_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] remove_time_q, read_confirm_ms_q, remove_grace_q;
  logic [15:0] refractory_q, enable_suppress_q, boot_warmup_q;
  logic [7:0]  reinit_misses_q, read_confirm_cnt_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remove_time_q      <= RST_REMOVE_TIME;
      reinit_misses_q    <= RST_REINIT_MISSES;
      read_confirm_ms_q  <= RST_READ_CONFIRM_MS;
      read_confirm_cnt_q <= RST_READ_CONFIRM_CNT;
      remove_grace_q     <= RST_REMOVE_GRACE;
      refractory_q       <= RST_REFRACTORY;
      enable_suppress_q  <= RST_ENABLE_SUPPRESS;
      boot_warmup_q      <= RST_BOOT_WARMUP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_REMOVE_TIME:      remove_time_q      <= pwdata[15:0];
        REG_REINIT_MISSES:    reinit_misses_q    <= pwdata[7:0];
        REG_READ_CONFIRM_MS:  read_confirm_ms_q  <= pwdata[15:0];
        REG_READ_CONFIRM_CNT: read_confirm_cnt_q <= pwdata[7:0];
        REG_REMOVE_GRACE:     remove_grace_q     <= pwdata[15:0];
        REG_REFRACTORY:       refractory_q       <= pwdata[15:0];
        REG_ENABLE_SUPPRESS:  enable_suppress_q  <= pwdata[15:0];
        REG_BOOT_WARMUP:      boot_warmup_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_REMOVE_TIME:      prdata = {16'd0, remove_time_q};
      REG_REINIT_MISSES:    prdata = {24'd0, reinit_misses_q};
      REG_READ_CONFIRM_MS:  prdata = {16'd0, read_confirm_ms_q};
      REG_READ_CONFIRM_CNT: prdata = {24'd0, read_confirm_cnt_q};
      REG_REMOVE_GRACE:     prdata = {16'd0, remove_grace_q};
      REG_REFRACTORY:       prdata = {16'd0, refractory_q};
      REG_ENABLE_SUPPRESS:  prdata = {16'd0, enable_suppress_q};
      REG_BOOT_WARMUP:      prdata = {16'd0, boot_warmup_q};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // pipe control: input register stage feeding the result register
  // ---------------------------------------------------------------------
  logic s1_valid_q, out_valid_q, advance;

  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // input register payload
  logic [1:0]             cmd_q;
  logic [TIME_BITS-1:0]   now_q;
  logic                   answered_q, read_ok_q;
  logic [UID_LO_BITS-1:0] uid_lo_q;
  logic [UID_HI_BITS-1:0] uid_hi_q;
  logic [3:0]             uid_len_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q      <= cmd_i;
      now_q      <= now_ms_i;
      answered_q <= card_answered_i;
      read_ok_q  <= uid_read_ok_i;
      uid_lo_q   <= uid_low_i;
      uid_hi_q   <= uid_high_i;
      uid_len_q  <= uid_length_i;
    end
  end

  // ---------------------------------------------------------------------
  // qualifier state
  // ---------------------------------------------------------------------
  logic                   enabled_q, enabled_d;
  logic [TIME_BITS-1:0]   last_enable_q, last_enable_d;
  logic [TIME_BITS-1:0]   dis_start_q, dis_start_d;
  logic                   card_present_q, card_present_d;
  logic                   published_q, published_d;
  logic                   rm_pend_q, rm_pend_d;
  logic [TIME_BITS-1:0]   rm_start_q, rm_start_d;
  logic [7:0]             fail_cnt_q, fail_cnt_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [UID_LO_BITS-1:0] pend_lo_q, pend_lo_d;
  logic [UID_HI_BITS-1:0] pend_hi_q, pend_hi_d;
  logic [3:0]             pend_len_q, pend_len_d;
  logic [7:0]             pend_cnt_q, pend_cnt_d;
  logic [TIME_BITS-1:0]   pend_start_q, pend_start_d;
  logic [TIME_BITS-1:0]   last_seen_q, last_seen_d;
  logic [TIME_BITS-1:0]   last_ev_time_q, last_ev_time_d;
  event_e                 last_ev_kind_q, last_ev_kind_d;
  logic [TIME_BITS-1:0]   sup_until_q, sup_until_d;

  // result values of the item in the input register
  event_e                 ev_d;
  logic [UID_LO_BITS-1:0] ev_lo_d;
  logic [UID_HI_BITS-1:0] ev_hi_d;
  logic                   reinit_d;

  // working signals of the single pass
  logic [3:0]             len;
  logic [UID_LO_BITS-1:0] lo_mask, lo;
  logic [UID_HI_BITS-1:0] hi_mask, hi;
  logic [TIME_BITS-1:0]   shift, warm_ext;
  logic [7:0]             fail_inc;
  logic                   seen, have_uid, fail_now, expired;
  logic                   rd_ok_time, rm_ok_time, rd_allowed, rm_allowed;

  always_comb begin
    enabled_d      = enabled_q;
    last_enable_d  = last_enable_q;
    dis_start_d    = dis_start_q;
    card_present_d = card_present_q;
    published_d    = published_q;
    rm_pend_d      = rm_pend_q;
    rm_start_d     = rm_start_q;
    fail_cnt_d     = fail_cnt_q;
    pend_valid_d   = pend_valid_q;
    pend_lo_d      = pend_lo_q;
    pend_hi_d      = pend_hi_q;
    pend_len_d     = pend_len_q;
    pend_cnt_d     = pend_cnt_q;
    pend_start_d   = pend_start_q;
    last_seen_d    = last_seen_q;
    last_ev_time_d = last_ev_time_q;
    last_ev_kind_d = last_ev_kind_q;
    sup_until_d    = sup_until_q;
    ev_d     = EV_NONE;
    ev_lo_d  = '0;
    ev_hi_d  = '0;
    reinit_d = 1'b0;

    // uid length saturates, bytes beyond it are dropped
    len = (uid_len_q > UID_MAX_LEN) ? UID_MAX_LEN : uid_len_q;
    for (int i = 0; i < 8; i++) begin
      lo_mask[i*8 +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
    end
    hi_mask[7:0]  = (len >= 4'd9) ? 8'hFF : 8'h00;
    hi_mask[15:8] = (len == UID_MAX_LEN) ? 8'hFF : 8'h00;
    lo = uid_lo_q & lo_mask;
    hi = uid_hi_q & hi_mask;

    shift    = now_q - dis_start_q;
    warm_ext = {{(TIME_BITS-16){1'b0}}, boot_warmup_q};
    // an answering card clears the count before a failed uid read counts
    fail_inc = (answered_q ? 8'd0 : fail_cnt_q) + 8'd1;
    seen     = 1'b0;
    have_uid = 1'b0;
    fail_now = 1'b0;

    rd_ok_time = (now_q - pend_start_q) >= {{(TIME_BITS-16){1'b0}}, read_confirm_ms_q};
    rm_ok_time = (now_q - rm_start_q) >= {{(TIME_BITS-16){1'b0}}, remove_grace_q};
    rd_allowed = !(last_ev_kind_q == EV_REMOVE &&
                   (now_q - last_ev_time_q) < {{(TIME_BITS-16){1'b0}}, refractory_q});
    rm_allowed = !(last_ev_kind_q == EV_READ &&
                   (now_q - last_ev_time_q) < {{(TIME_BITS-16){1'b0}}, refractory_q});
    expired = (remove_time_q == 16'd0) ||
              (last_seen_q != '0 &&
               (now_q - last_seen_q) >= {{(TIME_BITS-16){1'b0}}, remove_time_q});

    if (cmd_q == CMD_ENABLE || cmd_q == CMD_DISABLE) begin
      if ((cmd_q == CMD_ENABLE) != enabled_q) begin
        enabled_d     = (cmd_q == CMD_ENABLE);
        last_enable_d = now_q;
        if (cmd_q == CMD_ENABLE) begin
          // kept timestamps move forward by the disabled span
          if (dis_start_q != '0) begin
            if (shift != '0) begin
              if (last_seen_q != '0)    last_seen_d    = last_seen_q + shift;
              if (rm_start_q != '0)     rm_start_d     = rm_start_q + shift;
              if (last_ev_time_q != '0) last_ev_time_d = last_ev_time_q + shift;
            end
            dis_start_d = '0;
          end
          pend_valid_d = 1'b0;
          pend_lo_d    = '0;
          pend_hi_d    = '0;
          pend_len_d   = '0;
          pend_cnt_d   = '0;
          pend_start_d = '0;
          sup_until_d  = now_q + {{(TIME_BITS-16){1'b0}}, enable_suppress_q};
        end else begin
          dis_start_d = now_q;
        end
      end
    end else if (cmd_q == CMD_POLL && enabled_q && (now_q - last_enable_q) >= SETTLE_MS) begin
      if (!answered_q) begin
        fail_now = 1'b1;
      end else begin
        seen           = 1'b1;
        card_present_d = 1'b1;
        fail_cnt_d     = '0;
        last_seen_d    = now_q;
        if (read_ok_q) have_uid = (len != 4'd0);
        else fail_now = 1'b1;
      end

      // failure count reaching the limit drops pending read and removal
      if (fail_now) begin
        fail_cnt_d = fail_inc;
        if (fail_inc >= reinit_misses_q) begin
          reinit_d     = 1'b1;
          fail_cnt_d   = '0;
          pend_valid_d = 1'b0;
          pend_lo_d    = '0;
          pend_hi_d    = '0;
          pend_len_d   = '0;
          pend_cnt_d   = '0;
          pend_start_d = '0;
          rm_pend_d    = 1'b0;
          rm_start_d   = '0;
        end
      end

      if (have_uid) begin
        rm_pend_d  = 1'b0;
        rm_start_d = '0;
        priority if (last_enable_q != '0 && (now_q - last_enable_q) < ENABLE_READ_RESET_MS) begin
          // fresh after enable: restart confirmation
          pend_valid_d = 1'b1;
          pend_lo_d    = lo;
          pend_hi_d    = hi;
          pend_len_d   = len;
          pend_cnt_d   = 8'd1;
          pend_start_d = now_q;
        end else if (now_q < warm_ext) begin
          // warmup: prime the count so the next matching read meets the confirm count
          pend_valid_d = 1'b1;
          pend_lo_d    = lo;
          pend_hi_d    = hi;
          pend_len_d   = len;
          pend_cnt_d   = read_confirm_cnt_q;
          pend_start_d = now_q;
        end else if (published_q) begin
          pend_valid_d = 1'b0;
          pend_lo_d    = '0;
          pend_hi_d    = '0;
          pend_len_d   = '0;
          pend_cnt_d   = '0;
          pend_start_d = '0;
        end else if (!pend_valid_q || pend_len_q != len || pend_lo_q != lo ||
                     pend_hi_q != hi) begin
          pend_valid_d = 1'b1;
          pend_lo_d    = lo;
          pend_hi_d    = hi;
          pend_len_d   = len;
          pend_cnt_d   = 8'd1;
          pend_start_d = now_q;
        end else begin
          pend_cnt_d = (pend_cnt_q < COUNT_MAX) ? pend_cnt_q + 8'd1 : pend_cnt_q;
          if (pend_cnt_d >= read_confirm_cnt_q && rd_ok_time && rd_allowed) begin
            published_d    = 1'b1;
            pend_valid_d   = 1'b0;
            pend_lo_d      = '0;
            pend_hi_d      = '0;
            pend_len_d     = '0;
            pend_cnt_d     = '0;
            pend_start_d   = '0;
            last_ev_kind_d = EV_READ;
            last_ev_time_d = now_q;
            ev_d           = EV_READ;
            ev_lo_d        = lo;
            ev_hi_d        = hi;
          end
        end
      end else begin
        pend_valid_d = 1'b0;
        pend_lo_d    = '0;
        pend_hi_d    = '0;
        pend_len_d   = '0;
        pend_cnt_d   = '0;
        pend_start_d = '0;
        if (!seen && card_present_q && !(now_q < warm_ext) && !(now_q < sup_until_q) &&
            published_q && expired) begin
          // removal first goes pending, then needs the grace time
          if (!rm_pend_d) begin
            rm_pend_d  = 1'b1;
            rm_start_d = now_q;
          end else if (rm_ok_time && rm_allowed) begin
            card_present_d = 1'b0;
            published_d    = 1'b0;
            rm_pend_d      = 1'b0;
            rm_start_d     = '0;
            last_ev_kind_d = EV_REMOVE;
            last_ev_time_d = now_q;
            ev_d           = EV_REMOVE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b1;
      last_enable_q  <= '0;
      dis_start_q    <= '0;
      card_present_q <= 1'b0;
      published_q    <= 1'b0;
      rm_pend_q      <= 1'b0;
      rm_start_q     <= '0;
      fail_cnt_q     <= '0;
      pend_valid_q   <= 1'b0;
      pend_lo_q      <= '0;
      pend_hi_q      <= '0;
      pend_len_q     <= '0;
      pend_cnt_q     <= '0;
      pend_start_q   <= '0;
      last_seen_q    <= '0;
      last_ev_time_q <= '0;
      last_ev_kind_q <= EV_NONE;
      sup_until_q    <= ENABLE_SUPPRESS_DEFAULT;
    end else if (advance) begin
      enabled_q      <= enabled_d;
      last_enable_q  <= last_enable_d;
      dis_start_q    <= dis_start_d;
      card_present_q <= card_present_d;
      published_q    <= published_d;
      rm_pend_q      <= rm_pend_d;
      rm_start_q     <= rm_start_d;
      fail_cnt_q     <= fail_cnt_d;
      pend_valid_q   <= pend_valid_d;
      pend_lo_q      <= pend_lo_d;
      pend_hi_q      <= pend_hi_d;
      pend_len_q     <= pend_len_d;
      pend_cnt_q     <= pend_cnt_d;
      pend_start_q   <= pend_start_d;
      last_seen_q    <= last_seen_d;
      last_ev_time_q <= last_ev_time_d;
      last_ev_kind_q <= last_ev_kind_d;
      sup_until_q    <= sup_until_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_res_o      <= ev_d;
      event_uid_low_o  <= ev_lo_d;
      event_uid_high_o <= ev_hi_d;
      reinit_request_o <= reinit_d;
      card_published_o <= published_d;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_read_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_res_o == EV_READ |-> card_published_o)
    else $error("read event without published card");

  a_remove_unpublishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_res_o == EV_REMOVE |-> !card_published_o)
    else $error("remove event with card still published");

  a_reinit_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && reinit_request_o |-> event_res_o == EV_NONE)
    else $error("reinit request together with an event");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(now_q))
    else $error("input stage lost its item while stalled");

  a_state_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(published_q) && $stable(fail_cnt_q))
    else $error("qualifier state changed without an item");

endmodule

// ===== test/card_presence_event_qualifier_core_tb.sv =====
// testbench for the card presence event qualifier: directed table, random polls, scoreboard
module card_presence_event_qualifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpeq_pkg::*;

  // command code outside the enum, the block must treat it as a no-op
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned LONG_HOLD_AT = 180;
  localparam int unsigned LONG_HOLD_CYCLES = 64;

  // one poll or command as the sender offers it
  typedef struct packed {
    logic [1:0]             cmd;
    logic [TIME_BITS-1:0]   now;
    logic                   answered;
    logic                   read_ok;
    logic [UID_LO_BITS-1:0] uid_lo;
    logic [UID_HI_BITS-1:0] uid_hi;
    logic [3:0]             len;
  } poll_t;

  // one result transaction
  typedef struct packed {
    event_e                 ev;
    logic [UID_LO_BITS-1:0] uid_lo;
    logic [UID_HI_BITS-1:0] uid_hi;
    logic                   reinit;
    logic                   published;
  } verdict_t;

  // directed row: quiet rows carry a hand-typed result (no event, given published flag)
  typedef struct packed {
    poll_t txn;
    logic  quiet;
    logic  published;
  } dir_row_t;

  // dut ports
  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             cmd;
  logic [TIME_BITS-1:0]   now_ms;
  logic                   card_answered;
  logic                   uid_read_ok;
  logic [UID_LO_BITS-1:0] uid_low;
  logic [UID_HI_BITS-1:0] uid_high;
  logic [3:0]             uid_length;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             event_res;
  logic [UID_LO_BITS-1:0] event_uid_low;
  logic [UID_HI_BITS-1:0] event_uid_high;
  logic                   reinit_request;
  logic                   card_published;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_BITS-1:0]   paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // expected results, oldest first
  verdict_t verdict_q[$];

  // register image kept by the predictor, 8-bit registers zero-extended
  logic [15:0] cfg_reg [8];

  // predictor copy of the qualifier state
  logic        rdr_en;
  logic        card_seen;
  logic        card_pub;
  logic        rm_pending;
  logic        cand_valid;
  logic [31:0] enable_ts;
  logic [31:0] disable_ts;
  logic [31:0] rm_start;
  logic [31:0] cand_start;
  logic [31:0] seen_ts;
  logic [31:0] evt_ts;
  logic [31:0] rm_hold_until;
  logic [7:0]  miss_cnt;
  logic [7:0]  cand_cnt;
  logic [63:0] cand_lo;
  logic [15:0] cand_hi;
  logic [3:0]  cand_len;
  event_e      evt_kind;

  // random stimulus state: simulated millisecond clock and a small pool of cards
  logic [31:0] now_track;
  logic        tag_present;
  int unsigned tag_sel;
  logic [63:0] pool_lo [4];
  logic [15:0] pool_hi [4];
  logic [3:0]  pool_len [4];

  // idling control and run tallies
  logic        tx_idle_on;
  logic        rx_idle_on;
  int unsigned err_cnt;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_reads;
  int unsigned n_removes;
  int unsigned n_reinits;
  int unsigned cycle_cnt;

  card_presence_event_qualifier_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cmd),
    .now_ms_i         (now_ms),
    .card_answered_i  (card_answered),
    .uid_read_ok_i    (uid_read_ok),
    .uid_low_i        (uid_low),
    .uid_high_i       (uid_high),
    .uid_length_i     (uid_length),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_res_o      (event_res),
    .event_uid_low_o  (event_uid_low),
    .event_uid_high_o (event_uid_high),
    .reinit_request_o (reinit_request),
    .card_published_o (card_published),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // wrapping time difference
  function automatic logic [31:0] elapsed(logic [31:0] later, logic [31:0] earlier);
    return later - earlier;
  endfunction

  // zero means unset, so it is never shifted
  function automatic logic [31:0] shift_ts(logic [31:0] ts, logic [31:0] d);
    return (ts == 32'd0) ? ts : ts + d;
  endfunction

  // register value widened to a time
  function automatic logic [31:0] cfg_time(reg_idx_e idx);
    return {16'h0000, cfg_reg[idx]};
  endfunction

  function automatic void drop_candidate();
    cand_valid = 1'b0;
    cand_lo    = '0;
    cand_hi    = '0;
    cand_len   = '0;
    cand_cnt   = '0;
    cand_start = '0;
  endfunction

  function automatic void take_candidate(logic [63:0] lo, logic [15:0] hi, logic [3:0] len,
                                         logic [7:0] cnt, logic [31:0] t);
    cand_valid = 1'b1;
    cand_lo    = lo;
    cand_hi    = hi;
    cand_len   = len;
    cand_cnt   = cnt;
    cand_start = t;
  endfunction

  // failed poll; reaching the miss limit asks for reinit and clears pending work
  function automatic logic count_miss();
    miss_cnt = miss_cnt + 8'd1;
    if (miss_cnt >= cfg_reg[REG_REINIT_MISSES][7:0]) begin
      miss_cnt = '0;
      drop_candidate();
      rm_pending = 1'b0;
      rm_start   = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void reset_predictor();
    cfg_reg[REG_REMOVE_TIME]      = RST_REMOVE_TIME;
    cfg_reg[REG_REINIT_MISSES]    = {8'h00, RST_REINIT_MISSES};
    cfg_reg[REG_READ_CONFIRM_MS]  = RST_READ_CONFIRM_MS;
    cfg_reg[REG_READ_CONFIRM_CNT] = {8'h00, RST_READ_CONFIRM_CNT};
    cfg_reg[REG_REMOVE_GRACE]     = RST_REMOVE_GRACE;
    cfg_reg[REG_REFRACTORY]       = RST_REFRACTORY;
    cfg_reg[REG_ENABLE_SUPPRESS]  = RST_ENABLE_SUPPRESS;
    cfg_reg[REG_BOOT_WARMUP]      = RST_BOOT_WARMUP;
    rdr_en        = 1'b1;
    card_seen     = 1'b0;
    card_pub      = 1'b0;
    rm_pending    = 1'b0;
    enable_ts     = '0;
    disable_ts    = '0;
    rm_start      = '0;
    miss_cnt      = '0;
    seen_ts       = '0;
    evt_ts        = '0;
    evt_kind      = EV_NONE;
    rm_hold_until = ENABLE_SUPPRESS_DEFAULT;
    drop_candidate();
  endfunction

  // qualify one accepted transaction and return the result it must produce
  function automatic verdict_t predict_event(poll_t p);
    verdict_t    v;
    logic [3:0]  len;
    logic        want;
    logic        seen;
    logic        have_uid;
    logic        confirmed;
    logic        allowed;
    logic        expired;
    logic [63:0] lo;
    logic [63:0] lo_mask;
    logic [15:0] hi;
    logic [15:0] hi_mask;
    logic [31:0] d;
    v        = '0;
    v.ev     = EV_NONE;
    seen     = 1'b0;
    have_uid = 1'b0;
    lo       = '0;
    hi       = '0;
    len      = (p.len > UID_MAX_LEN) ? UID_MAX_LEN : p.len;

    if (p.cmd == CMD_ENABLE || p.cmd == CMD_DISABLE) begin
      want = (p.cmd == CMD_ENABLE);
      if (want != rdr_en) begin
        rdr_en    = want;
        enable_ts = p.now;
        if (want) begin
          // kept timestamps move forward by the time spent disabled
          if (disable_ts != 32'd0) begin
            d = elapsed(p.now, disable_ts);
            if (d != 32'd0) begin
              seen_ts    = shift_ts(seen_ts, d);
              cand_start = shift_ts(cand_start, d);
              rm_start   = shift_ts(rm_start, d);
              evt_ts     = shift_ts(evt_ts, d);
            end
            disable_ts = '0;
          end
          drop_candidate();
          rm_hold_until = p.now + cfg_time(REG_ENABLE_SUPPRESS);
        end else begin
          disable_ts = p.now;
        end
      end
    end else if (p.cmd == CMD_POLL && rdr_en && elapsed(p.now, enable_ts) >= SETTLE_MS) begin
      if (!p.answered) begin
        if (count_miss()) v.reinit = 1'b1;
      end else begin
        seen      = 1'b1;
        card_seen = 1'b1;
        miss_cnt  = '0;
        seen_ts   = p.now;
        if (p.read_ok) begin
          if (len != 4'd0) begin
            lo_mask  = (len >= 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            hi_mask  = (len == 4'd10) ? 16'hFFFF : (len == 4'd9) ? 16'h00FF : 16'h0000;
            lo       = p.uid_lo & lo_mask;
            hi       = p.uid_hi & hi_mask;
            have_uid = 1'b1;
          end
        end else if (count_miss()) begin
          v.reinit = 1'b1;
        end
      end

      if (have_uid) begin
        rm_pending = 1'b0;
        rm_start   = '0;
        if (enable_ts != 32'd0 && elapsed(p.now, enable_ts) < ENABLE_READ_RESET_MS) begin
          take_candidate(lo, hi, len, 8'd1, p.now);
        end else if (p.now < cfg_time(REG_BOOT_WARMUP)) begin
          // during warmup the candidate starts already counted
          take_candidate(lo, hi, len, cfg_reg[REG_READ_CONFIRM_CNT][7:0], p.now);
        end else if (card_pub) begin
          drop_candidate();
        end else if (!cand_valid || cand_len != len || cand_lo != lo || cand_hi != hi) begin
          take_candidate(lo, hi, len, 8'd1, p.now);
        end else begin
          if (cand_cnt < COUNT_MAX) cand_cnt = cand_cnt + 8'd1;
          confirmed = cand_cnt >= cfg_reg[REG_READ_CONFIRM_CNT][7:0] &&
                      elapsed(p.now, cand_start) >= cfg_time(REG_READ_CONFIRM_MS);
          allowed   = !(evt_kind == EV_REMOVE &&
                        elapsed(p.now, evt_ts) < cfg_time(REG_REFRACTORY));
          if (confirmed && allowed) begin
            card_pub = 1'b1;
            drop_candidate();
            evt_kind = EV_READ;
            evt_ts   = p.now;
            v.ev     = EV_READ;
            v.uid_lo = lo;
            v.uid_hi = hi;
          end
        end
      end else begin
        drop_candidate();
        if (!seen && card_seen && !(p.now < cfg_time(REG_BOOT_WARMUP) ||
                                    p.now < rm_hold_until || !card_pub)) begin
          expired = (cfg_reg[REG_REMOVE_TIME] == 16'd0) ||
                    (seen_ts != 32'd0 &&
                     elapsed(p.now, seen_ts) >= cfg_time(REG_REMOVE_TIME));
          if (expired) begin
            if (!rm_pending) begin
              rm_pending = 1'b1;
              rm_start   = p.now;
            end else begin
              confirmed = elapsed(p.now, rm_start) >= cfg_time(REG_REMOVE_GRACE);
              allowed   = !(evt_kind == EV_READ &&
                            elapsed(p.now, evt_ts) < cfg_time(REG_REFRACTORY));
              if (confirmed && allowed) begin
                card_seen  = 1'b0;
                card_pub   = 1'b0;
                rm_pending = 1'b0;
                rm_start   = '0;
                evt_kind   = EV_REMOVE;
                evt_ts     = p.now;
                v.ev       = EV_REMOVE;
              end
            end
          end
        end
      end
    end
    v.published = card_pub;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t dir_row(logic [1:0] c, logic [31:0] t, logic ans, logic ok,
                                       logic [63:0] lo, logic [15:0] hi, logic [3:0] len,
                                       logic quiet, logic pub);
    dir_row_t r;
    r.txn      = '{c, t, ans, ok, lo, hi, len};
    r.quiet    = quiet;
    r.published = pub;
    return r;
  endfunction

  // new card pool: the usual uid lengths plus one arbitrary length
  function automatic void refresh_pool();
    for (int i = 0; i < 4; i++) begin
      pool_lo[i] = {$urandom, $urandom};
      pool_hi[i] = 16'($urandom);
    end
    pool_len[0] = 4'd4;
    pool_len[1] = 4'd7;
    pool_len[2] = 4'd10;
    pool_len[3] = 4'($urandom_range(0, 15));
  endfunction

  // next random transaction: cards come and go, time mostly moves forward
  function automatic poll_t next_poll();
    poll_t       p;
    int unsigned r;
    int unsigned pick;
    r = $urandom_range(0, 99);
    if (r < 70)      now_track = now_track + $urandom_range(10, 120);
    else if (r < 90) now_track = now_track + $urandom_range(120, 700);
    else if (r < 97) now_track = now_track + $urandom_range(0, 40);
    else             now_track = now_track + $urandom_range(1000, 5000);

    if ($urandom_range(0, 9) == 0) begin
      tag_present = !tag_present;
      if (tag_present) tag_sel = $urandom_range(0, 3);
    end

    // fields that the item does not use still carry garbage
    p.cmd      = CMD_POLL;
    p.now      = now_track;
    p.answered = 1'b0;
    p.read_ok  = 1'b0;
    p.uid_lo   = {$urandom, $urandom};
    p.uid_hi   = 16'($urandom);
    p.len      = 4'($urandom);

    r = $urandom_range(0, 99);
    if (r < 6) begin
      p.cmd = CMD_ENABLE;
    end else if (r < 9) begin
      p.cmd = CMD_DISABLE;
    end else if (r < 10) begin
      p.cmd = CMD_UNKNOWN;
    end else if (r < 13) begin
      // noise: anything at any time
      p.cmd      = 2'($urandom_range(0, 3));
      p.now      = $urandom;
      p.answered = 1'($urandom);
      p.read_ok  = 1'($urandom);
    end else if (tag_present) begin
      pick       = $urandom_range(0, 99);
      p.answered = 1'b1;
      p.read_ok  = 1'b1;
      p.uid_lo   = pool_lo[tag_sel];
      p.uid_hi   = pool_hi[tag_sel];
      p.len      = pool_len[tag_sel];
      if (pick < 5) begin
        p.read_ok = 1'b0;
      end else if (pick < 9) begin
        p.len = 4'd0;
      end else if (pick < 15) begin
        pick     = $urandom_range(0, 3);
        p.uid_lo = pool_lo[pick];
        p.uid_hi = pool_hi[pick];
        p.len    = pool_len[pick];
      end
    end else if ($urandom_range(0, 11) == 0) begin
      p.answered = 1'b1;
      p.read_ok  = 1'($urandom);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch in %s at result %0d: expected %h, got %h", what, n_checked, want, got);
  endtask

  // offer one transaction, hold it until accepted, then queue its expected result
  task automatic offer(poll_t p, logic quiet, logic pub);
    verdict_t v;
    @(negedge clk);
    in_valid      <= 1'b1;
    cmd           <= p.cmd;
    now_ms        <= p.now;
    card_answered <= p.answered;
    uid_read_ok   <= p.read_ok;
    uid_low       <= p.uid_lo;
    uid_high      <= p.uid_hi;
    uid_length    <= p.len;
    do @(posedge clk); while (!in_ready);
    v = predict_event(p);
    // hand-typed rows still run the predictor so that its state follows the block
    if (quiet) v = '{EV_NONE, 64'h0, 16'h0, 1'b0, pub};
    verdict_q.push_back(v);
    n_sent++;
  endtask

  // sender gap: in_valid low for a random stretch between two offers
  task automatic idle_gap();
    int unsigned n;
    n = $urandom_range(1, 18);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop offering until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write, then read back
  task automatic set_reg(reg_idx_e idx, logic [15:0] val);
    logic [15:0] stored;
    stored = (idx == REG_REINIT_MISSES || idx == REG_READ_CONFIRM_CNT) ?
             {8'h00, val[7:0]} : val;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_reg[idx] = stored;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'h0000, stored})
      report_mismatch("register readback", 64'(stored), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold, and the scoreboard
  // ---------------------------------------------------------------------------

  initial begin
    logic        long_done;
    int unsigned n;
    long_done = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_done && n_checked >= LONG_HOLD_AT) begin
        // long hold: the pipe fills and the sender sees in_ready drop
        long_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("result with nothing outstanding: event %0d", event_res);
      end else begin
        want = verdict_q.pop_front();
        if (event_res !== want.ev)
          report_mismatch("event_res", 64'(want.ev), 64'(event_res));
        if (event_uid_low !== want.uid_lo)
          report_mismatch("event_uid_low", want.uid_lo, event_uid_low);
        if (event_uid_high !== want.uid_hi)
          report_mismatch("event_uid_high", 64'(want.uid_hi), 64'(event_uid_high));
        if (reinit_request !== want.reinit)
          report_mismatch("reinit_request", 64'(want.reinit), 64'(reinit_request));
        if (card_published !== want.published)
          report_mismatch("card_published", 64'(want.published), 64'(card_published));
        n_checked++;
      end
      if (event_res == EV_READ) n_reads++;
      if (event_res == EV_REMOVE) n_removes++;
      if (reinit_request) n_reinits++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    dir_rows[$];
    logic [15:0] vals [8];
    logic [63:0] uid_a_lo;
    logic [63:0] uid_b_lo;
    int unsigned n_items;

    // every input known from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    cmd           = CMD_POLL;
    now_ms        = '0;
    card_answered = 1'b0;
    uid_read_ok   = 1'b0;
    uid_low       = '0;
    uid_high      = '0;
    uid_length    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_cnt       = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_reads       = 0;
    n_removes     = 0;
    n_reinits     = 0;
    cycle_cnt     = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    tag_present   = 1'b0;
    tag_sel       = 0;
    now_track     = '0;
    reset_predictor();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset register values
    uid_a_lo = 64'h0123_4567_CAFE_F00D;
    uid_b_lo = 64'hA5A5_5A5A_0F0F_F0F0;
    // poll inside the settling window after reset is ignored
    dir_rows.push_back(dir_row(CMD_POLL, 32'd10, 1, 1, uid_a_lo, 16'hFFFF, 4'd4, 1, 0));
    // unknown command, every bit high
    dir_rows.push_back(dir_row(CMD_UNKNOWN, 32'd100, 1, 1, '1, '1, 4'hF, 1, 0));
    // enable while already enabled
    dir_rows.push_back(dir_row(CMD_ENABLE, 32'd120, 0, 0, '0, '0, 4'd0, 1, 0));
    // boot warmup holds the read back
    dir_rows.push_back(dir_row(CMD_POLL, 32'd100, 1, 1, uid_a_lo, 16'hFFFF, 4'd4, 1, 0));
    // same uid after warmup confirms a read, high bytes masked off
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3000, 1, 1, uid_a_lo, 16'hFFFF, 4'd4, 0, 0));
    // long uid saturates to ten bytes while published
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3010, 1, 1, '1, '1, 4'hF, 0, 0));
    // empty uid is an answer without a uid
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3020, 1, 1, uid_a_lo, 16'h0, 4'd0, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3030, 0, 0, '0, '0, 4'd0, 0, 0));
    // answer with failed uid read counts a miss
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3040, 1, 0, uid_a_lo, 16'h0, 4'd4, 0, 0));
    // removal: timeout, grace, then the event
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3600, 0, 0, '0, '0, 4'd0, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3700, 0, 0, '0, '0, 4'd0, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd3800, 0, 0, '0, '0, 4'd0, 0, 0));
    // disable, redundant disable, poll while disabled
    dir_rows.push_back(dir_row(CMD_DISABLE, 32'd4000, 0, 0, '0, '0, 4'd0, 0, 0));
    dir_rows.push_back(dir_row(CMD_DISABLE, 32'd4010, 0, 0, '0, '0, 4'd0, 1, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd5000, 1, 1, uid_b_lo, 16'h1234, 4'd7, 1, 0));
    // enable shifts kept timestamps by the disabled time
    dir_rows.push_back(dir_row(CMD_ENABLE, 32'd6000, 0, 0, '0, '0, 4'd0, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd6020, 1, 1, uid_b_lo, 16'h1234, 4'd7, 1, 0));
    // read right after enable restarts the count, then confirms
    dir_rows.push_back(dir_row(CMD_POLL, 32'd6050, 1, 1, uid_b_lo, 16'h1234, 4'd7, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd6100, 1, 1, uid_b_lo, 16'h1234, 4'd7, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd6200, 1, 1, uid_b_lo, 16'h1234, 4'd7, 0, 0));
    // time extremes and wrap through zero
    dir_rows.push_back(dir_row(CMD_POLL, 32'hFFFF_FFF0, 1, 1, uid_b_lo, 16'h1234, 4'd7, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'hFFFF_FFFF, 0, 0, '1, '1, 4'hF, 0, 0));
    dir_rows.push_back(dir_row(CMD_POLL, 32'd0, 0, 0, '0, '0, 4'd0, 0, 0));
    foreach (dir_rows[i]) offer(dir_rows[i].txn, dir_rows[i].quiet, dir_rows[i].published);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      refresh_pool();
      case (ph)
        0, 4: begin
          vals[REG_REMOVE_TIME]      = 16'($urandom_range(0, 600));
          vals[REG_REINIT_MISSES]    = 16'($urandom_range(1, 12));
          vals[REG_READ_CONFIRM_MS]  = 16'($urandom_range(0, 200));
          vals[REG_READ_CONFIRM_CNT] = 16'($urandom_range(1, 4));
          vals[REG_REMOVE_GRACE]     = 16'($urandom_range(0, 300));
          vals[REG_REFRACTORY]       = 16'($urandom_range(0, 400));
          vals[REG_ENABLE_SUPPRESS]  = 16'($urandom_range(0, 300));
          vals[REG_BOOT_WARMUP]      = 16'($urandom_range(0, 3000));
        end
        1: begin
          // all zero: reinit on every miss, zero confirm count acts like one
          foreach (vals[r]) vals[r] = 16'h0000;
        end
        2: begin
          // all at maximum
          foreach (vals[r]) vals[r] = 16'hFFFF;
          vals[REG_REINIT_MISSES]    = 16'h00FF;
          vals[REG_READ_CONFIRM_CNT] = 16'h00FF;
        end
        default: begin
          // fast qualification, one miss requests reinit
          vals[REG_REMOVE_TIME]      = 16'($urandom_range(0, 50));
          vals[REG_REINIT_MISSES]    = 16'd1;
          vals[REG_READ_CONFIRM_MS]  = 16'($urandom_range(0, 30));
          vals[REG_READ_CONFIRM_CNT] = 16'd1;
          vals[REG_REMOVE_GRACE]     = 16'($urandom_range(0, 50));
          vals[REG_REFRACTORY]       = 16'($urandom_range(0, 60));
          vals[REG_ENABLE_SUPPRESS]  = 16'($urandom_range(0, 60));
          vals[REG_BOOT_WARMUP]      = 16'd0;
        end
      endcase
      for (int r = 0; r < 8; r++) set_reg(reg_idx_e'(r), vals[r]);

      // start of the simulated clock: near boot first, near the wrap in the max phase
      if (ph == 0) now_track = 32'd100;
      if (ph == 2) now_track = 32'hFFFF_F000;
      n_items = (ph == 2) ? 60 : (ph == 4) ? 130 : 90;
      // last phase runs with no idling on either side
      tx_idle_on = (ph != 4);
      rx_idle_on = (ph != 4);
      for (int k = 0; k < n_items; k++) begin
        if (tx_idle_on && $urandom_range(0, 4) == 0) idle_gap();
        offer(next_poll(), 1'b0, 1'b0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d transactions: directed table, then five register settings",
             n_sent);
    $display("%0d results checked: %0d reads, %0d removals, %0d reinit requests",
             n_checked, n_reads, n_removes, n_reinits);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== card_presence_event_qualifier_core.f =====
rtl/cpeq_pkg.sv
rtl/card_presence_event_qualifier_core.sv
test/card_presence_event_qualifier_core_tb.sv
